// ===== hdl/fcc_pkg.sv =====
// Shared types, codes and helpers for the FAT cluster chain read sequencer.
`timescale 1ns / 1ps

package fcc_pkg;

    // Input function codes
    localparam logic [1:0] FUNC_FAT_WRITE = 2'd0;
    localparam logic [1:0] FUNC_START     = 2'd1;
    localparam logic [1:0] FUNC_REQUEST   = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_ISSUED     = 3'd0;
    localparam logic [2:0] ST_NO_CMD     = 3'd1;
    localparam logic [2:0] ST_BAD_START  = 3'd2;
    localparam logic [2:0] ST_CHAIN_END  = 3'd3;
    localparam logic [2:0] ST_NOT_ACTIVE = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] REG_HEAP_OFFSET = 2'd0;
    localparam logic [1:0] REG_CLUSTER_SHIFT = 2'd1;
    localparam logic [1:0] REG_FAT_COUNT = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // Cluster numbering
    localparam logic [31:0] FIRST_DATA_CLUSTER = 32'd2;
    localparam logic [31:0] LAST_VALID_CLUSTER = 32'hFFFF_FFF6;
    localparam logic [31:0] END_OF_CHAIN       = 32'hFFFF_FFFF;

    // Cluster size shift limits and reset value
    localparam logic [4:0] SHIFT_MIN   = 5'd9;
    localparam logic [4:0] SHIFT_MAX   = 5'd25;
    localparam logic [4:0] SHIFT_RESET = 5'd12;

    // Width of in-cluster byte counts (cluster is at most 2^25 bytes)
    localparam int DONE_W = 26;

    // Command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] fat_index;
        logic [31:0] fat_value;
        logic [31:0] start_cluster;
        logic [63:0] file_length;
        logic        contiguous;
    } in_t;

    typedef struct packed {
        logic [63:0] read_offset;
        logic [16:0] read_length;
        logic        last_chunk;
        logic [2:0]  status;
    } out_t;

    typedef enum logic [1:0] {
        OP_FAT_WR = 2'd0,
        OP_START  = 2'd1,
        OP_REQ    = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    // Classified command as held in the queue
    typedef struct packed {
        op_t         op;
        logic        start_ok;
        logic        len_zero;
        logic [15:0] fat_index;
        logic [31:0] fat_value;
        logic [31:0] start_cluster;
        logic [63:0] file_length;
        logic        contiguous;
    } cmd_t;

    function automatic logic cluster_ok(input logic [31:0] c);
        cluster_ok = (c >= FIRST_DATA_CLUSTER) && (c <= LAST_VALID_CLUSTER);
    endfunction

endpackage

// ===== hdl/fat_cluster_chain_read_sequencer.sv =====
// Top level of the FAT cluster chain read sequencer.
//
// Input channel s_*: one transaction per function code - write a FAT entry,
// start a file (first cluster, byte length, contiguous flag) or ask for the
// next read command. Every input transaction yields exactly one result
// transaction on m_* carrying offset, length, last marker and status.
// Configuration (heap offset, cluster shift, FAT entry count) is written
// through cfg_wr_en/cfg_index/cfg_wr_data; the user must do so only while
// the block is idle, which the block itself does not enforce. A two-entry
// command queue sits between the decode front end and the sequencing back
// end. A FAT write, file start or unused code goes from idle through the
// execute state into the result register; a request goes through the request
// states. The back end handles one command at a time; when finishing a cluster
// needs the next entry from the registered FAT memory read, it goes via S_FAT.
// Reset (aresetn low, synchronous) empties the queue and result register,
// ends any active file and restores the register defaults; the FAT store
// holds whatever was written before. When m_ready is low the finished
// result is held and the back end waits, while the queue keeps taking input
// until it is full.
`timescale 1ns / 1ps

module fat_cluster_chain_read_sequencer #(
    parameter int FAT_DEPTH   = 65536,
    parameter int CHUNK_BYTES = 65536
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  fcc_pkg::in_t                    s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output fcc_pkg::out_t                   m_data,
    input  logic                            cfg_wr_en,
    input  logic [fcc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fcc_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);

    logic           q_valid;
    fcc_pkg::cmd_t  q_data;
    logic           q_pop;

    fcc_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop)
    );

    fcc_back #(
        .FAT_DEPTH   (FAT_DEPTH),
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

// ===== hdl/fcc_front.sv =====
// Front end: accepts input transactions, classifies them and queues commands.
`timescale 1ns / 1ps

module fcc_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  fcc_pkg::in_t    s_data,
    output logic            q_valid,
    output fcc_pkg::cmd_t   q_data,
    input  logic            q_pop
);

    fcc_pkg::cmd_t                  queue_reg [fcc_pkg::QDEPTH];
    logic [fcc_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [fcc_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [fcc_pkg::QCNT_W-1:0]     count_reg, count_next;
    fcc_pkg::cmd_t                  entry;
    logic                           push;
    logic                           pop;

    // Decode function code and pre-check the start parameters
    always_comb begin
        entry.fat_index     = s_data.fat_index;
        entry.fat_value     = s_data.fat_value;
        entry.start_cluster = s_data.start_cluster;
        entry.file_length   = s_data.file_length;
        entry.contiguous    = s_data.contiguous;
        entry.start_ok      = fcc_pkg::cluster_ok(s_data.start_cluster);
        entry.len_zero      = (s_data.file_length == 64'd0);
        case (s_data.func)
            fcc_pkg::FUNC_FAT_WRITE: entry.op = fcc_pkg::OP_FAT_WR;
            fcc_pkg::FUNC_START:     entry.op = fcc_pkg::OP_START;
            fcc_pkg::FUNC_REQUEST:   entry.op = fcc_pkg::OP_REQ;
            default:                 entry.op = fcc_pkg::OP_NOP;
        endcase
    end

    // Queue control
    assign s_ready = (count_reg != fcc_pkg::QCNT_W'(fcc_pkg::QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = queue_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

// ===== hdl/fcc_back.sv =====
// Back end: FAT store, file state, chunk sequencing and the result register.
`timescale 1ns / 1ps

module fcc_back #(
    parameter int FAT_DEPTH   = 65536,
    parameter int CHUNK_BYTES = 65536
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [fcc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fcc_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                            q_valid,
    input  fcc_pkg::cmd_t                   q_data,
    output logic                            q_pop,
    output logic                            m_valid,
    input  logic                            m_ready,
    output fcc_pkg::out_t                   m_data
);

    localparam int AW = $clog2(FAT_DEPTH);
    localparam int DW = fcc_pkg::DONE_W;
    localparam logic [31:0]   DEPTH_W = 32'(FAT_DEPTH);
    localparam logic [DW-1:0] CHUNK_W = DW'(CHUNK_BYTES);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_REQ1 = 6'b000100,
        S_REQ2 = 6'b001000,
        S_REQ3 = 6'b010000,
        S_FAT  = 6'b100000
    } state_t;

    // FAT store
    logic [31:0]    fat_mem [FAT_DEPTH];
    logic [31:0]    fat_rd_reg;

    // Control and file state
    state_t         state_reg, state_next;
    logic           active_reg, active_next;
    logic [31:0]    cur_reg, cur_next;
    logic [63:0]    rem_reg, rem_next;
    logic [DW-1:0]  done_reg, done_next;
    logic           consec_reg, consec_next;

    // Configuration
    logic [63:0]    heap_reg;
    logic [4:0]     shift_reg;
    logic [16:0]    count_reg;

    // Per-command working registers
    fcc_pkg::cmd_t  cmd_reg, cmd_next;
    logic [DW-1:0]  want_reg, want_next;
    logic [63:0]    base_reg, base_next;
    logic [63:0]    part_reg, part_next;
    logic [DW-1:0]  chunk_reg, chunk_next;

    // Result register
    logic           out_valid_reg, out_valid_next;
    fcc_pkg::out_t  out_reg, out_next;

    logic           out_free;
    logic           out_load;
    logic           mem_we;
    logic [31:0]    wr_idx;
    logic           wr_in_range;
    logic [4:0]     sh;
    logic [63:0]    csize;
    logic [31:0]    cur_m2;
    logic [DW-1:0]  left;
    logic [DW-1:0]  done_sum;
    logic [63:0]    rem_fin;
    logic           fin_zero;
    logic           finish;
    logic           lookup_oor;

    assign out_free = !out_valid_reg || m_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    // Datapath terms
    always_comb begin
        if (shift_reg < fcc_pkg::SHIFT_MIN) begin
            sh = fcc_pkg::SHIFT_MIN;
        end else if (shift_reg > fcc_pkg::SHIFT_MAX) begin
            sh = fcc_pkg::SHIFT_MAX;
        end else begin
            sh = shift_reg;
        end
    end

    assign csize       = 64'd1 << sh;
    assign cur_m2      = cur_reg - fcc_pkg::FIRST_DATA_CLUSTER;
    assign left        = want_reg - done_reg;
    assign done_sum    = done_reg + chunk_reg;
    assign rem_fin     = rem_reg - 64'(want_reg);
    assign fin_zero    = (rem_fin == 64'd0);
    assign wr_idx      = {16'd0, cmd_reg.fat_index};
    assign wr_in_range = (wr_idx < DEPTH_W);
    assign lookup_oor  = (cur_reg >= {15'd0, count_reg}) || (cur_reg >= DEPTH_W);

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        active_next    = active_reg;
        cur_next       = cur_reg;
        rem_next       = rem_reg;
        done_next      = done_reg;
        consec_next    = consec_reg;
        cmd_next       = cmd_reg;
        want_next      = want_reg;
        base_next      = base_reg;
        part_next      = part_reg;
        chunk_next     = chunk_reg;
        out_next       = '0;
        out_next.status = fcc_pkg::ST_NO_CMD;
        out_load       = 1'b0;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        finish         = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    cmd_next   = q_data;
                    state_next = (q_data.op == fcc_pkg::OP_REQ) ? S_REQ1 : S_EXEC;
                end
            end

            // FAT write, file start and unused codes
            S_EXEC: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                    case (cmd_reg.op)
                        fcc_pkg::OP_FAT_WR: begin
                            mem_we = wr_in_range;
                        end
                        fcc_pkg::OP_START: begin
                            active_next = 1'b0;
                            done_next   = '0;
                            if (cmd_reg.len_zero) begin
                                out_next.status = fcc_pkg::ST_NO_CMD;
                            end else if (!cmd_reg.start_ok) begin
                                out_next.status = fcc_pkg::ST_BAD_START;
                            end else begin
                                active_next = 1'b1;
                                cur_next    = cmd_reg.start_cluster;
                                rem_next    = cmd_reg.file_length;
                                consec_next = cmd_reg.contiguous;
                            end
                        end
                        default: begin
                            out_next.status = fcc_pkg::ST_NO_CMD;
                        end
                    endcase
                end
            end

            // Request: check state, size the cluster extent and base
            S_REQ1: begin
                if (!active_reg) begin
                    if (out_free) begin
                        out_load        = 1'b1;
                        out_next.status = fcc_pkg::ST_NOT_ACTIVE;
                        state_next      = S_IDLE;
                    end
                end else if (!fcc_pkg::cluster_ok(cur_reg)) begin
                    if (out_free) begin
                        out_load        = 1'b1;
                        out_next.status = fcc_pkg::ST_CHAIN_END;
                        active_next     = 1'b0;
                        state_next      = S_IDLE;
                    end
                end else begin
                    want_next  = (rem_reg < csize) ? rem_reg[DW-1:0] : csize[DW-1:0];
                    base_next  = {32'd0, cur_m2} << sh;
                    state_next = S_REQ2;
                end
            end

            // Cluster already covered (shift shrank) or size the chunk
            S_REQ2: begin
                if (done_reg >= want_reg) begin
                    if (out_free) begin
                        out_load        = 1'b1;
                        out_next.status = fcc_pkg::ST_NO_CMD;
                        finish          = 1'b1;
                    end
                end else begin
                    chunk_next = (left > CHUNK_W) ? CHUNK_W : left;
                    part_next  = heap_reg + base_reg;
                    state_next = S_REQ3;
                end
            end

            // Issue the read command
            S_REQ3: begin
                if (out_free) begin
                    out_load             = 1'b1;
                    out_next.status      = fcc_pkg::ST_ISSUED;
                    out_next.read_offset = part_reg + 64'(done_reg);
                    out_next.read_length = chunk_reg[16:0];
                    if (done_sum == want_reg) begin
                        finish              = 1'b1;
                        out_next.last_chunk = fin_zero;
                    end else begin
                        done_next  = done_sum;
                        state_next = S_IDLE;
                    end
                end
            end

            // fat_rd_reg holds the entry at cur_reg, read on the way in
            S_FAT: begin
                cur_next   = lookup_oor ? fcc_pkg::END_OF_CHAIN : fat_rd_reg;
                state_next = S_IDLE;
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Close the current cluster and move to the next one
        if (finish) begin
            rem_next  = rem_fin;
            done_next = '0;
            if (fin_zero) begin
                active_next = 1'b0;
                state_next  = S_IDLE;
            end else if (consec_reg) begin
                cur_next   = cur_reg + 32'd1;
                state_next = S_IDLE;
            end else begin
                state_next = S_FAT;
            end
        end

        // Result register
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            active_reg    <= 1'b0;
            cur_reg       <= '0;
            rem_reg       <= '0;
            done_reg      <= '0;
            consec_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            heap_reg      <= '0;
            shift_reg     <= fcc_pkg::SHIFT_RESET;
            count_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            cur_reg       <= cur_next;
            rem_reg       <= rem_next;
            done_reg      <= done_next;
            consec_reg    <= consec_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    fcc_pkg::REG_HEAP_OFFSET:   heap_reg  <= cfg_wr_data;
                    fcc_pkg::REG_CLUSTER_SHIFT: shift_reg <= cfg_wr_data[4:0];
                    fcc_pkg::REG_FAT_COUNT:     count_reg <= cfg_wr_data[16:0];
                    default: ;
                endcase
            end
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        want_reg  <= want_next;
        base_reg  <= base_next;
        part_reg  <= part_next;
        chunk_reg <= chunk_next;
        if (out_load) begin
            out_reg <= out_next;
        end
    end

    // FAT memory: one write port, one registered read port at the current cluster
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            fat_mem[wr_idx[AW-1:0]] <= cmd_reg.fat_value;
        end
        fat_rd_reg <= fat_mem[cur_reg[AW-1:0]];
    end

endmodule
